/* sv/i2cm_pkg.sv */
package i2cm_pkg;

	// Command codes carried by the action field
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_PROBE = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_HALF_BIT   = 2'd0;
	localparam logic [1:0] CFG_START_STOP = 2'd1;
	localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;
	localparam logic [1:0] CFG_STOP_GAP   = 2'd3;

	// Configuration reset values
	localparam logic [7:0]  HALF_BIT_RST   = 8'd2;
	localparam logic [7:0]  START_STOP_RST = 8'd4;
	localparam logic [7:0]  POLL_LIMIT_RST = 8'd250;
	localparam logic [15:0] STOP_GAP_RST   = 16'd2000;

	// Byte step marking a failed (timed out) transfer
	localparam logic [2:0] STEP_FAIL = 3'd7;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [7:0]  half_bit_ticks;
		logic [7:0]  start_stop_ticks;
		logic [7:0]  ack_poll_limit;
		logic [15:0] stop_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic       nack_error;
		logic [7:0] rd_data;
	} res_t;

endpackage

/* sv/i2c_master_register_access_top.sv */
// I2C master for single register access. Every input transaction is one bus
// timing tick with the sampled SDA level; a nonzero action given while idle
// starts a write, read or address probe, and each tick returns exactly one
// result transaction with the SCL/SDA drive levels (1 = release), busy, a
// one-tick done pulse with nack_error, and the last byte read. A tick is
// taken every clock cycle while input stall is low: the sequencer state updates
// in one pass and the result leaves from an output register. One skid entry
// sits behind that register, so input stall rises only once it holds a result
// behind a stalled output, and drops right after the output takes one. Timing
// registers are written through the cfg port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module i2c_master_register_access_top
	import i2cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [6:0]            dev_addr,
	input  logic [7:0]            reg_addr,
	input  logic [7:0]            wr_data,
	input  logic                  sda_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  busy_res,
	output logic                  done_res,
	output logic                  nack_error,
	output logic [7:0]            rd_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	res_t res_c, res_o;
	logic acc;
	logic full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_ticks   <= HALF_BIT_RST;
			cfg_q.start_stop_ticks <= START_STOP_RST;
			cfg_q.ack_poll_limit   <= POLL_LIMIT_RST;
			cfg_q.stop_gap_ticks   <= STOP_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_BIT:   cfg_q.half_bit_ticks   <= cfg_data[7:0];
				CFG_START_STOP: cfg_q.start_stop_ticks <= cfg_data[7:0];
				CFG_POLL_LIMIT: cfg_q.ack_poll_limit   <= cfg_data[7:0];
				CFG_STOP_GAP:   cfg_q.stop_gap_ticks   <= cfg_data;
			endcase
		end
	end

	assign in_stall = full;
	assign acc      = in_valid && !full;

	assign cmd.action   = action;
	assign cmd.dev_addr = dev_addr;
	assign cmd.reg_addr = reg_addr;
	assign cmd.wr_data  = wr_data;

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.cmd    (cmd),
		.sda_in (sda_in),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	i2cm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.res_in    (res_c),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_o)
	);

	assign scl_level  = res_o.scl_level;
	assign sda_level  = res_o.sda_level;
	assign busy_res   = res_o.busy_res;
	assign done_res   = res_o.done_res;
	assign nack_error = res_o.nack_error;
	assign rd_data    = res_o.rd_data;

	// Skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry valid while output register empty");

	// Done always comes while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> busy_res)
		else $error("done without busy");

	// Error flag only on the done tick
	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && nack_error) |-> done_res)
		else $error("nack_error outside done");

	// A stalled output full of data fills the skid when a transaction is accepted
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && in_valid && !in_stall) |=> in_stall)
		else $error("accepted transaction lost behind stalled output");

endmodule

/* sv/i2cm_seq.sv */
module i2cm_seq
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  cmd_t       cmd,
	input  logic       sda_in,
	input  cfg_t       cfg,
	output res_t       res
);

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_STA_A    = 5'd1,
		PH_STA_B    = 5'd2,
		PH_REP      = 5'd3,
		PH_TX_LO    = 5'd4,
		PH_TX_HI    = 5'd5,
		PH_ACK_LO   = 5'd6,
		PH_ACK_HI   = 5'd7,
		PH_ACK_POLL = 5'd8,
		PH_RX_LO    = 5'd9,
		PH_RX_HI    = 5'd10,
		PH_NK_LO    = 5'd11,
		PH_NK_HI    = 5'd12,
		PH_SP_A     = 5'd13,
		PH_SP_B     = 5'd14,
		PH_SP_C     = 5'd15,
		PH_GAP      = 5'd16,
		PH_DONE     = 5'd17
	} phase_t;

	phase_t      phase_q, phase_c, ph0;
	logic [3:0]  bit_cnt_q, bit_cnt_c, bit0;
	logic [2:0]  step_q, step_c, step0;
	logic [7:0]  shift_q, shift_c, sh0;
	logic [15:0] tick_q, tick_c, tick0;
	logic [7:0]  poll_q, poll_c, poll0;
	cmd_t        cmd_q, cmd_c;
	logic [7:0]  rd_byte_q, rd_byte_c;

	logic        start;
	logic [15:0] dur;
	logic [16:0] tsum;
	logic        fire;
	logic [7:0]  psum;
	logic [3:0]  bit_inc;
	logic [1:0]  drive;

	// Command pickup while idle
	always_comb begin
		start = (phase_q == PH_IDLE) && (cmd.action != ACT_NONE);
		ph0   = start ? PH_STA_A : phase_q;
		bit0  = start ? 4'd0 : bit_cnt_q;
		step0 = start ? 3'd0 : step_q;
		sh0   = start ? 8'd0 : shift_q;
		tick0 = start ? 16'd0 : tick_q;
		poll0 = start ? 8'd0 : poll_q;
		cmd_c = start ? cmd : cmd_q;
	end

	// Shared tick timer: duration picked by phase
	always_comb begin
		unique case (ph0)
			PH_STA_A, PH_STA_B, PH_SP_A, PH_SP_B, PH_SP_C:
				dur = {8'd0, cfg.start_stop_ticks};
			PH_GAP:
				dur = cfg.stop_gap_ticks;
			default:
				dur = {8'd0, cfg.half_bit_ticks};
		endcase
		tsum    = {1'b0, tick0} + 17'd1;
		fire    = tsum >= {1'b0, dur};
		psum    = poll0 + 8'd1;
		bit_inc = bit0 + 4'd1;
	end

	// Bus drive levels, bit 1 = SCL, bit 0 = SDA
	always_comb begin
		unique case (ph0)
			PH_STA_B, PH_SP_B:                       drive = 2'b10;
			PH_REP, PH_ACK_LO, PH_RX_LO, PH_NK_LO:   drive = 2'b01;
			PH_TX_LO:                                drive = {1'b0, sh0[7]};
			PH_TX_HI:                                drive = {1'b1, sh0[7]};
			PH_SP_A:                                 drive = 2'b00;
			default:                                 drive = 2'b11;
		endcase
	end

	// Result for this transaction
	always_comb begin
		res.scl_level  = drive[1];
		res.sda_level  = drive[0];
		res.busy_res   = (ph0 != PH_IDLE);
		res.done_res   = (ph0 == PH_DONE);
		res.nack_error = (ph0 == PH_DONE) && (step0 == STEP_FAIL);
		res.rd_data    = rd_byte_q;
	end

	// Next state
	always_comb begin
		phase_c   = ph0;
		bit_cnt_c = bit0;
		step_c    = step0;
		shift_c   = sh0;
		poll_c    = poll0;
		rd_byte_c = rd_byte_q;
		tick_c    = tick0;
		if (ph0 != PH_IDLE) begin
			unique case (ph0)
				PH_STA_A, PH_STA_B, PH_REP, PH_TX_LO, PH_TX_HI, PH_ACK_LO, PH_ACK_HI,
				PH_RX_LO, PH_RX_HI, PH_NK_LO, PH_NK_HI, PH_SP_A, PH_SP_B, PH_SP_C,
				PH_GAP:
					tick_c = fire ? 16'd0 : tsum[15:0];
				default:
					tick_c = tick0;
			endcase
			unique case (ph0)
				PH_STA_A: if (fire) phase_c = PH_STA_B;
				PH_STA_B: if (fire) begin
					shift_c   = {cmd_c.dev_addr, (step0 == 3'd2)};
					bit_cnt_c = 4'd0;
					phase_c   = PH_TX_LO;
				end
				PH_REP:    if (fire) phase_c = PH_STA_A;
				PH_TX_LO:  if (fire) phase_c = PH_TX_HI;
				PH_TX_HI:  if (fire) begin
					shift_c   = {sh0[6:0], 1'b0};
					bit_cnt_c = bit_inc;
					phase_c   = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
				end
				PH_ACK_LO: if (fire) phase_c = PH_ACK_HI;
				PH_ACK_HI: if (fire) begin
					poll_c  = 8'd0;
					phase_c = PH_ACK_POLL;
				end
				PH_ACK_POLL: begin
					if (!sda_in) begin
						// acknowledged: pick the next byte of the transfer
						priority if (cmd_c.action == ACT_PROBE) begin
							phase_c = PH_SP_A;
						end else if (step0 == 3'd0) begin
							step_c    = 3'd1;
							shift_c   = cmd_c.reg_addr;
							bit_cnt_c = 4'd0;
							phase_c   = PH_TX_LO;
						end else if (cmd_c.action == ACT_WRITE) begin
							if (step0 == 3'd1) begin
								step_c    = 3'd2;
								shift_c   = cmd_c.wr_data;
								bit_cnt_c = 4'd0;
								phase_c   = PH_TX_LO;
							end else begin
								phase_c = PH_SP_A;
							end
						end else if (step0 == 3'd1) begin
							step_c  = 3'd2;
							phase_c = PH_REP;
						end else begin
							step_c    = 3'd3;
							shift_c   = 8'd0;
							bit_cnt_c = 4'd0;
							phase_c   = PH_RX_LO;
						end
					end else begin
						poll_c = psum;
						if (psum >= cfg.ack_poll_limit) begin
							step_c  = STEP_FAIL;
							phase_c = PH_SP_A;
						end
					end
				end
				PH_RX_LO:  if (fire) phase_c = PH_RX_HI;
				PH_RX_HI:  if (fire) begin
					shift_c   = {sh0[6:0], sda_in};
					bit_cnt_c = bit_inc;
					phase_c   = (bit_inc >= 4'd8) ? PH_NK_LO : PH_RX_LO;
				end
				PH_NK_LO:  if (fire) phase_c = PH_NK_HI;
				PH_NK_HI:  if (fire) begin
					rd_byte_c = sh0;
					phase_c   = PH_SP_A;
				end
				PH_SP_A:   if (fire) phase_c = PH_SP_B;
				PH_SP_B:   if (fire) phase_c = PH_SP_C;
				PH_SP_C:   if (fire) begin
					if (step0 == STEP_FAIL || cmd_c.action == ACT_PROBE ||
					    cfg.stop_gap_ticks == 16'd0)
						phase_c = PH_DONE;
					else
						phase_c = PH_GAP;
				end
				PH_GAP:    if (fire) phase_c = PH_DONE;
				default: begin
					phase_c = PH_IDLE;
					tick_c  = 16'd0;
				end
			endcase
		end
	end

	// State registers, updated once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			step_q    <= '0;
			shift_q   <= '0;
			tick_q    <= '0;
			poll_q    <= '0;
			cmd_q     <= '0;
			rd_byte_q <= '0;
		end else if (acc) begin
			phase_q   <= phase_c;
			bit_cnt_q <= bit_cnt_c;
			step_q    <= step_c;
			shift_q   <= shift_c;
			tick_q    <= tick_c;
			poll_q    <= poll_c;
			cmd_q     <= cmd_c;
			rd_byte_q <= rd_byte_c;
		end
	end

endmodule

/* sv/i2cm_obuf.sv */
module i2cm_obuf
	import i2cm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t res_in,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t res_out
);

	logic out_vld_q, skid_vld_q;
	res_t out_q, skid_q;
	logic slot_free;

	assign slot_free = !out_vld_q || !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = out_vld_q;
	assign res_out   = out_q;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (slot_free) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Payload moves without reset
	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_q <= skid_vld_q ? skid_q : res_in;
		end else if (push) begin
			skid_q <= res_in;
		end
	end

endmodule
